>>> design/dqcl_pkg.sv
// Shared constants and types for the dq current reference limiter.
// No dependencies; imported by the top level.
package dqcl_pkg;

    localparam int DATA_W  = 16;
    localparam int LIM_W   = 15;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIRCLE_LIMIT = 2'd0,
        CFG_D_UPPER      = 2'd1,
        CFG_D_LOWER      = 2'd2,
        CFG_Q_BOUND      = 2'd3
    } t_cfg_idx;

    localparam logic [LIM_W-1:0]         RST_CIRCLE_LIMIT = 15'd4096;
    localparam logic signed [DATA_W-1:0] RST_D_UPPER      = 16'sd4096;
    localparam logic signed [DATA_W-1:0] RST_D_LOWER      = -16'sd4096;
    localparam logic [LIM_W-1:0]         RST_Q_BOUND      = 15'd4096;

endpackage

>>> design/dqcl_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a side word alongside each beat. No dependencies.
module dqcl_isqrt #(
    parameter int RAD_W  = 30,
    parameter int SIDE_W = 1,
    localparam int ROOT_W = (RAD_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              r_vld  [ROOT_W+1];
    logic [PAD_W-1:0]  r_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic [SIDE_W-1:0] r_side [ROOT_W+1];

    assign r_vld[0]  = i_valid;
    assign r_rad[0]  = PAD_W'(i_rad);
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] n_rem;
        logic [REM_W-1:0] n_trial;
        logic             n_take;

        // bring down the next two radicand bits, try root*4+1
        assign n_rem   = {r_rem[k][REM_W-3:0], r_rad[k][PAD_W-1 -: 2]};
        assign n_trial = REM_W'({r_root[k], 2'b01});
        assign n_take  = (n_rem >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k+1]  <= r_rad[k] << 2;
            r_rem[k+1]  <= n_take ? (n_rem - n_trial) : n_rem;
            r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_take};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

>>> design/dqcl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient must fit QUO_W bits. Carries a side word. No dependencies.
module dqcl_div #(
    parameter int NUM_W  = 39,
    parameter int DEN_W  = 24,
    parameter int QUO_W  = 15,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic              r_vld  [QUO_W+1];
    logic [W-1:0]      r_rem  [QUO_W+1];
    logic [DEN_W-1:0]  r_den  [QUO_W+1];
    logic [QUO_W-1:0]  r_quo  [QUO_W+1];
    logic [SIDE_W-1:0] r_side [QUO_W+1];

    assign r_vld[0]  = i_valid;
    assign r_rem[0]  = W'(i_num);
    assign r_den[0]  = i_den;
    assign r_quo[0]  = '0;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [W-1:0] n_sub;
        logic         n_take;

        assign n_sub  = W'(r_den[k]) << SH;
        assign n_take = (r_rem[k] >= n_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_take ? (r_rem[k] - n_sub) : r_rem[k];
            r_den[k+1]  <= r_den[k];
            r_quo[k+1]  <= {r_quo[k][QUO_W-2:0], n_take};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

>>> design/dq_current_reference_limiter.sv
// Top level of the dq current reference limiter: config registers and pipeline.
// Depends on dqcl_pkg, dqcl_isqrt and dqcl_div.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------
//  command  | i_start, o_busy                 | i_d_request, i_q_request
//  config   | i_cfg_valid, o_cfg_ready        | i_cfg_index, i_cfg_data
//  result   | o_valid (one-cycle strobe)      | o_d_limited, o_q_limited
//
// One pair is accepted every cycle; o_busy stays low.
// The pipeline holds the magnitude root (24 stages), the scaling
// dividers (15), two 15-stage roots for the circle fit, plus 10 glue stages.
// Synchronous active-low reset clears all valid bits and restores registers.
// Results cannot be stalled; each beat appears for exactly one cycle.
module dq_current_reference_limiter
    import dqcl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_d_request,
    input  logic signed [DATA_W-1:0] i_q_request,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_d_limited,
    output logic signed [DATA_W-1:0] o_q_limited
);

    localparam int SQ_W   = 2 * LIM_W;        // L^2 and radicands
    localparam int PSQ_W  = 2 * DATA_W - 1;   // square of a 16-bit value
    localparam int SUM_W  = 2 * DATA_W;
    localparam int MRAD_W = SUM_W + 16;
    localparam int MAG_W  = (MRAD_W + 1) / 2;
    localparam int PROD_W = DATA_W + LIM_W;
    localparam int NUM_W  = PROD_W + 8;
    localparam int RT_W   = (SQ_W + 1) / 2;

    // ---------------- configuration ----------------
    logic [LIM_W-1:0]         r_circle_limit;
    logic signed [DATA_W-1:0] r_d_upper;
    logic signed [DATA_W-1:0] r_d_lower;
    logic [LIM_W-1:0]         r_q_bound;
    logic [SQ_W-1:0]          r_lim_sq;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circle_limit <= RST_CIRCLE_LIMIT;
            r_d_upper      <= RST_D_UPPER;
            r_d_lower      <= RST_D_LOWER;
            r_q_bound      <= RST_Q_BOUND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CIRCLE_LIMIT: r_circle_limit <= i_cfg_data[LIM_W-1:0];
                CFG_D_UPPER:      r_d_upper      <= i_cfg_data;
                CFG_D_LOWER:      r_d_lower      <= i_cfg_data;
                CFG_Q_BOUND:      r_q_bound      <= i_cfg_data[LIM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_sq <= SQ_W'(r_circle_limit) * SQ_W'(r_circle_limit);
    end

    // ---------------- stage 1: capture ----------------
    logic                     r1_vld;
    logic signed [DATA_W-1:0] r1_d, r1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= i_start && !o_busy;
    end
    always_ff @(posedge i_clk) begin
        r1_d <= i_d_request;
        r1_q <= i_q_request;
    end

    // ---------------- stage 2: squares, magnitudes ----------------
    logic                     r2_vld;
    logic [PSQ_W-1:0]         r2_dsq, r2_qsq;
    logic [DATA_W-1:0]        r2_dabs, r2_qabs;
    logic signed [DATA_W-1:0] r2_d, r2_q;
    logic signed [SUM_W-1:0]  n2_dsq, n2_qsq;

    assign n2_dsq = r1_d * r1_d;
    assign n2_qsq = r1_q * r1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        r2_dsq  <= n2_dsq[PSQ_W-1:0];
        r2_qsq  <= n2_qsq[PSQ_W-1:0];
        r2_dabs <= r1_d[DATA_W-1] ? (~r1_d + 16'd1) : r1_d;
        r2_qabs <= r1_q[DATA_W-1] ? (~r1_q + 16'd1) : r1_q;
        r2_d    <= r1_d;
        r2_q    <= r1_q;
    end

    // ---------------- stage 3: sum, circle test, numerators ----------------
    logic                     r3_vld;
    logic [SUM_W-1:0]         r3_sum;
    logic                     r3_scale;
    logic [PROD_W-1:0]        r3_dprod, r3_qprod;
    logic signed [DATA_W-1:0] r3_d, r3_q;
    logic [SUM_W-1:0]         n3_sum;

    assign n3_sum = SUM_W'(r2_dsq) + SUM_W'(r2_qsq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
    end
    always_ff @(posedge i_clk) begin
        r3_sum   <= n3_sum;
        r3_scale <= (n3_sum > SUM_W'(r_lim_sq));
        r3_dprod <= PROD_W'(SUM_W'(r2_dabs) * SUM_W'(r_circle_limit));
        r3_qprod <= PROD_W'(SUM_W'(r2_qabs) * SUM_W'(r_circle_limit));
        r3_d     <= r2_d;
        r3_q     <= r2_q;
    end

    // ---------------- magnitude root ----------------
    localparam int SA_W = 1 + 2 * DATA_W + 2 * PROD_W;
    logic              ma_vld;
    logic [MAG_W-1:0]  ma_mag;
    logic [SA_W-1:0]   ma_side;

    dqcl_isqrt #(.RAD_W(MRAD_W), .SIDE_W(SA_W)) u_mag_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_rad   ({r3_sum, 16'd0}),
        .i_side  ({r3_scale, r3_d, r3_q, r3_dprod, r3_qprod}),
        .o_valid (ma_vld),
        .o_root  (ma_mag),
        .o_side  (ma_side)
    );

    logic                     ma_scale;
    logic signed [DATA_W-1:0] ma_d, ma_q;
    logic [PROD_W-1:0]        ma_dprod, ma_qprod;

    assign {ma_scale, ma_d, ma_q, ma_dprod, ma_qprod} = ma_side;

    // ---------------- scaling dividers ----------------
    logic                     dv_vld, dq_vld;
    logic [LIM_W-1:0]         dv_dquo, dv_qquo;
    logic                     dv_scale;
    logic signed [DATA_W-1:0] dv_d, dv_q;

    dqcl_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .QUO_W(LIM_W),
               .SIDE_W(1 + DATA_W)) u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ma_vld),
        .i_num   ({ma_dprod, 8'd0}),
        .i_den   (ma_mag),
        .i_side  ({ma_scale, ma_d}),
        .o_valid (dv_vld),
        .o_quo   (dv_dquo),
        .o_side  ({dv_scale, dv_d})
    );

    dqcl_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .QUO_W(LIM_W),
               .SIDE_W(DATA_W)) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ma_vld),
        .i_num   ({ma_qprod, 8'd0}),
        .i_den   (ma_mag),
        .i_side  (ma_q),
        .o_valid (dq_vld),
        .o_quo   (dv_qquo),
        .o_side  (dv_q)
    );

    // ---------------- stage 4: apply scale, clamp ----------------
    logic signed [DATA_W-1:0] n4_dquo, n4_qquo, n4_dsc, n4_qsc;
    logic signed [DATA_W-1:0] n4_dup, n4_dc, n4_qbs, n4_qc;
    logic [DATA_W-1:0]        n4_qabs;

    always_comb begin
        n4_dquo = signed'({1'b0, dv_dquo});
        n4_qquo = signed'({1'b0, dv_qquo});
        n4_dsc  = dv_scale ? (dv_d[DATA_W-1] ? -n4_dquo : n4_dquo) : dv_d;
        n4_qsc  = dv_scale ? (dv_q[DATA_W-1] ? -n4_qquo : n4_qquo) : dv_q;
        // upper first, lower wins when the bounds cross
        n4_dup  = (n4_dsc > r_d_upper) ? r_d_upper : n4_dsc;
        n4_dc   = (n4_dup < r_d_lower) ? r_d_lower : n4_dup;
        n4_qabs = n4_qsc[DATA_W-1] ? (~n4_qsc + 16'd1) : n4_qsc;
        n4_qbs  = signed'({1'b0, r_q_bound});
        n4_qc   = n4_qsc;
        if (n4_qabs > {1'b0, r_q_bound}) begin
            n4_qc = (n4_qsc > 16'sd0) ? n4_qbs : -n4_qbs;
        end
    end

    logic                     r4_vld, r4_dneg;
    logic signed [DATA_W-1:0] r4_d, r4_q;
    logic [DATA_W-1:0]        r4_qabs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= dv_vld;
    end
    always_ff @(posedge i_clk) begin
        r4_d    <= n4_dc;
        r4_q    <= n4_qc;
        r4_qabs <= n4_qabs;
        r4_dneg <= dv_d[DATA_W-1];
    end

    // ---------------- stage 5: squares of clamped pair ----------------
    logic                     r5_vld, r5_dneg;
    logic [PSQ_W-1:0]         r5_dsq, r5_qsq;
    logic signed [DATA_W-1:0] r5_d, r5_q;
    logic [DATA_W-1:0]        r5_qabs;
    logic signed [SUM_W-1:0]  n5_dsq, n5_qsq;

    assign n5_dsq = r4_d * r4_d;
    assign n5_qsq = r4_q * r4_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else          r5_vld <= r4_vld;
    end
    always_ff @(posedge i_clk) begin
        r5_dsq  <= n5_dsq[PSQ_W-1:0];
        r5_qsq  <= n5_qsq[PSQ_W-1:0];
        r5_d    <= r4_d;
        r5_q    <= r4_q;
        r5_qabs <= r4_qabs;
        r5_dneg <= r4_dneg;
    end

    // ---------------- stage 6: outside test, radicand ----------------
    logic                     r6_vld, r6_out, r6_dneg;
    logic [SQ_W-1:0]          r6_rad;
    logic signed [DATA_W-1:0] r6_d, r6_q;
    logic [DATA_W-1:0]        r6_qabs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else          r6_vld <= r5_vld;
    end
    always_ff @(posedge i_clk) begin
        r6_out  <= (SUM_W'(r5_dsq) + SUM_W'(r5_qsq)) > SUM_W'(r_lim_sq);
        r6_rad  <= (PSQ_W'(r_lim_sq) >= r5_qsq) ? SQ_W'(PSQ_W'(r_lim_sq) - r5_qsq) : '0;
        r6_d    <= r5_d;
        r6_q    <= r5_q;
        r6_qabs <= r5_qabs;
        r6_dneg <= r5_dneg;
    end

    // ---------------- q fit root ----------------
    localparam int SB_W = 2 + 3 * DATA_W;
    logic                     rb_vld, rb_out, rb_dneg;
    logic [RT_W-1:0]          rb_safe;
    logic signed [DATA_W-1:0] rb_d, rb_q;
    logic [DATA_W-1:0]        rb_qabs;

    dqcl_isqrt #(.RAD_W(SQ_W), .SIDE_W(SB_W)) u_q_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_rad   (r6_rad),
        .i_side  ({r6_out, r6_d, r6_q, r6_qabs, r6_dneg}),
        .o_valid (rb_vld),
        .o_root  (rb_safe),
        .o_side  ({rb_out, rb_d, rb_q, rb_qabs, rb_dneg})
    );

    // ---------------- stage 7: pull q in ----------------
    logic signed [DATA_W-1:0] n7_safe, n7_q;

    always_comb begin
        n7_safe = signed'(DATA_W'(rb_safe));
        n7_q    = rb_q;
        if (rb_out && (DATA_W'(rb_safe) < rb_qabs)) begin
            n7_q = (rb_q > 16'sd0) ? n7_safe : -n7_safe;
        end
    end

    logic                     r7_vld, r7_out, r7_dneg;
    logic signed [DATA_W-1:0] r7_d, r7_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else          r7_vld <= rb_vld;
    end
    always_ff @(posedge i_clk) begin
        r7_out  <= rb_out;
        r7_d    <= rb_d;
        r7_q    <= n7_q;
        r7_dneg <= rb_dneg;
    end

    // ---------------- stages 8, 9: radicand for d ----------------
    logic                     r8_vld, r8_out, r8_dneg;
    logic [PSQ_W-1:0]         r8_qsq;
    logic signed [DATA_W-1:0] r8_d, r8_q;
    logic signed [SUM_W-1:0]  n8_qsq;

    assign n8_qsq = r7_q * r7_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_vld <= 1'b0;
        else          r8_vld <= r7_vld;
    end
    always_ff @(posedge i_clk) begin
        r8_qsq  <= n8_qsq[PSQ_W-1:0];
        r8_out  <= r7_out;
        r8_d    <= r7_d;
        r8_q    <= r7_q;
        r8_dneg <= r7_dneg;
    end

    logic                     r9_vld, r9_out, r9_dneg;
    logic [SQ_W-1:0]          r9_rad;
    logic signed [DATA_W-1:0] r9_d, r9_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_vld <= 1'b0;
        else          r9_vld <= r8_vld;
    end
    always_ff @(posedge i_clk) begin
        r9_rad  <= (PSQ_W'(r_lim_sq) >= r8_qsq) ? SQ_W'(PSQ_W'(r_lim_sq) - r8_qsq) : '0;
        r9_out  <= r8_out;
        r9_d    <= r8_d;
        r9_q    <= r8_q;
        r9_dneg <= r8_dneg;
    end

    // ---------------- d rebuild root ----------------
    localparam int SC_W = 2 + 2 * DATA_W;
    logic                     rc_vld, rc_out, rc_dneg;
    logic [RT_W-1:0]          rc_root;
    logic signed [DATA_W-1:0] rc_d, rc_q;

    dqcl_isqrt #(.RAD_W(SQ_W), .SIDE_W(SC_W)) u_d_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_vld),
        .i_rad   (r9_rad),
        .i_side  ({r9_out, r9_d, r9_q, r9_dneg}),
        .o_valid (rc_vld),
        .o_root  (rc_root),
        .o_side  ({rc_out, rc_d, rc_q, rc_dneg})
    );

    // ---------------- output register ----------------
    logic                     r_out_vld, r_out_fit;
    logic signed [DATA_W-1:0] r_out_d, r_out_q;
    logic signed [DATA_W-1:0] n_root;

    assign n_root = signed'(DATA_W'(rc_root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= rc_vld;
    end
    always_ff @(posedge i_clk) begin
        r_out_d   <= rc_out ? (rc_dneg ? -n_root : n_root) : rc_d;
        r_out_q   <= rc_q;
        r_out_fit <= rc_out;
    end

    assign o_valid     = r_out_vld;
    assign o_d_limited = r_out_d;
    assign o_q_limited = r_out_q;

    // ---------------- assertions ----------------
    logic signed [SUM_W-1:0] a_dsq, a_qsq;
    assign a_dsq = r_out_d * r_out_d;
    assign a_qsq = r_out_q * r_out_q;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld == dq_vld)
        else $error("divider lanes out of step");

    a_fit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_fit) |->
            (SUM_W'(a_dsq) + SUM_W'(a_qsq)) <= SUM_W'(r_lim_sq))
        else $error("fitted vector lies outside the circle");

    a_scale_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_vld && $past(dv_scale)) |->
            ($past(n4_qabs) <= DATA_W'(r_circle_limit)))
        else $error("scaled q exceeds the circle radius");

endmodule

>>> tb/sv/dq_limit_checker.sv
// Checker for the dq current reference limiter: tracks register writes, predicts each
// limited pair and compares it with the result beats. Depends on dqcl_pkg.
`timescale 1ns / 100ps
module dq_limit_checker
    import dqcl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [DATA_W-1:0] i_d_request,
    input  logic signed [DATA_W-1:0] i_q_request,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_d_limited,
    input  logic signed [DATA_W-1:0] i_q_limited,
    output int                       o_errors,
    output int                       o_pending
);

    typedef struct {
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] q;
    } t_dq_pair;

    logic [LIM_W-1:0]         circle_lim;
    logic signed [DATA_W-1:0] d_upper;
    logic signed [DATA_W-1:0] d_lower;
    logic [LIM_W-1:0]         q_lim;
    t_dq_pair                 limited_fifo[$];

    initial o_errors = 0;
    assign o_pending = limited_fifo.size();

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_word(longint x);
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x[DATA_W-1:0];
    endfunction

    function automatic t_dq_pair limit_pair(logic signed [DATA_W-1:0] d_in,
                                            logic signed [DATA_W-1:0] q_in);
        longint d, q, lim, lim2, qabs, rad, fit;
        longint unsigned mag, ad, aq;
        bit d_neg;
        t_dq_pair r;
        d     = d_in;
        q     = q_in;
        d_neg = d < 0;
        lim   = circle_lim;
        lim2  = lim * lim;
        // scale onto the circle, truncating toward zero
        if (d * d + q * q > lim2) begin
            mag = root_floor(longint'(d * d + q * q) << 16);
            ad  = d < 0 ? -d : d;
            aq  = q < 0 ? -q : q;
            ad  = ((ad * lim) << 8) / mag;
            aq  = ((aq * lim) << 8) / mag;
            d   = d < 0 ? -longint'(ad) : longint'(ad);
            q   = q < 0 ? -longint'(aq) : longint'(aq);
        end
        if (d > d_upper) d = d_upper;
        if (d < d_lower) d = d_lower;
        qabs = q < 0 ? -q : q;
        if (qabs > longint'(q_lim)) q = (q > 0) ? longint'(q_lim) : -longint'(q_lim);
        if (d * d + q * q > lim2) begin
            rad = lim2 - q * q;
            if (rad < 0) rad = 0;
            fit = root_floor(rad);
            if (fit < qabs) q = (q > 0) ? fit : -fit;
            rad = lim2 - q * q;
            if (rad < 0) rad = 0;
            d = root_floor(rad);
            if (d_neg) d = -d;
        end
        r.d = sat_word(d);
        r.q = sat_word(q);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_dq_pair want;
        if (!i_rst_n) begin
            circle_lim = RST_CIRCLE_LIMIT;
            d_upper    = RST_D_UPPER;
            d_lower    = RST_D_LOWER;
            q_lim      = RST_Q_BOUND;
        end else begin
            if (i_valid) begin
                if (limited_fifo.size() == 0) begin
                    report_mismatch("unexpected result beat", i_d_limited, 0);
                end else begin
                    want = limited_fifo.pop_front();
                    if (i_d_limited !== want.d) report_mismatch("d_limited", i_d_limited, want.d);
                    if (i_q_limited !== want.q) report_mismatch("q_limited", i_q_limited, want.q);
                end
            end
            if (i_start && !i_busy) limited_fifo.push_back(limit_pair(i_d_request, i_q_request));
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CIRCLE_LIMIT: circle_lim = i_cfg_data[LIM_W-1:0];
                    CFG_D_UPPER:      d_upper    = i_cfg_data;
                    CFG_D_LOWER:      d_lower    = i_cfg_data;
                    CFG_Q_BOUND:      q_lim      = i_cfg_data[LIM_W-1:0];
                endcase
            end
        end
    end

endmodule

>>> tb/sv/dq_current_reference_limiter_test.sv
// Top of the dq current reference limiter testbench: clock, reset, stimulus, verdict.
// Depends on dqcl_pkg, dq_current_reference_limiter and dq_limit_checker.
`timescale 1ns / 100ps
module dq_current_reference_limiter_test;
    import dqcl_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic signed [DATA_W-1:0] i_d_request = '0;
    logic signed [DATA_W-1:0] i_q_request = '0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_d_limited;
    logic signed [DATA_W-1:0] o_q_limited;
    int                       mismatches;
    int                       pending;
    int                       quiet_cycles = 0;
    int                       idle_pct = 12;

    always #10 i_clk = ~i_clk;

    dq_current_reference_limiter DUT (.*);

    dq_limit_checker checker_inst (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_d_request, .i_q_request,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_valid(o_valid), .i_d_limited(o_d_limited), .i_q_limited(o_q_limited),
        .o_errors(mismatches), .o_pending(pending)
    );

    // count cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("dq_current_reference_limiter_test: FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_pair(logic signed [DATA_W-1:0] d, logic signed [DATA_W-1:0] q);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_d_request <= d;
        i_q_request <= q;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // drain the pipeline, then load all four registers
    task automatic set_limits(logic [DATA_W-1:0] lim, logic [DATA_W-1:0] dup,
                              logic [DATA_W-1:0] dlo, logic [DATA_W-1:0] qb);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        write_reg(CFG_CIRCLE_LIMIT, lim);
        write_reg(CFG_D_UPPER, dup);
        write_reg(CFG_D_LOWER, dlo);
        write_reg(CFG_Q_BOUND, qb);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_current(int lim);
        int span;
        span = lim + lim / 4 + 1;
        case ($urandom_range(3))
            0: return DATA_W'($urandom);
            1: return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
            2: return DATA_W'(int'($urandom_range(0, 64)) - 32);
            default: return DATA_W'(($urandom_range(1) ? 32767 : -32768)
                                    - int'($urandom_range(0, 3)));
        endcase
    endfunction

    initial begin
        logic [DATA_W-1:0] lim, dup, dlo, qb;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes under reset limits
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(-16'sh8000, -16'sh8000);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sh8000, 16'sd0);
        send_pair(16'sd0, 16'sh7fff);
        send_pair(16'sd2000, -16'sd3000);
        send_pair(16'sd4096, 16'sd0);
        send_pair(16'sd2896, 16'sd2897);
        // zero circle, d bounds keeping the clamped d off zero
        set_limits(16'h0000, 16'sd500, 16'sd100, 16'd0);
        send_pair(16'sd1000, 16'sd1000);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd5, 16'sd0);
        // widest circle, extreme bounds, top data bit set on the 15-bit registers
        set_limits(16'hffff, 16'sh7fff, -16'sh8000, 16'hffff);
        send_pair(16'sh7fff, -16'sh8000);
        send_pair(-16'sh8000, 16'sh7fff);
        send_pair(-16'sh8000, -16'sh8000);
        // crossed d bounds: lower wins
        set_limits(16'd3000, -16'sd1000, 16'sd1000, 16'd2000);
        send_pair(-16'sd2000, 16'sd2500);
        send_pair(16'sd2800, -16'sd2800);
        send_pair(16'sd0, 16'sd0);
        // q bound zero
        set_limits(16'd4096, 16'sd4096, -16'sd4096, 16'd0);
        send_pair(16'sd5000, 16'sd5000);
        send_pair(-16'sd1, -16'sd100);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin lim = 16'd4096; dup = 16'd4096; dlo = -16'sd4096; qb = 16'd4096; end
                1: begin
                    lim = 16'd0; dup = DATA_W'($urandom);
                    dlo = DATA_W'($urandom); qb = DATA_W'($urandom);
                end
                2: begin lim = 16'h7fff; dup = 16'h7fff; dlo = 16'h8000; qb = 16'h7fff; end
                default: begin
                    lim = DATA_W'($urandom); dup = DATA_W'($urandom_range(0, 8000));
                    dlo = DATA_W'(-int'($urandom_range(0, 8000))); qb = DATA_W'($urandom);
                    if ($urandom_range(3) == 0) dlo = DATA_W'($urandom);
                end
            endcase
            set_limits(lim, dup, dlo, qb);
            idle_pct = (phase == 3) ? 0 : 12;
            repeat (125) send_pair(pick_current(int'(lim[LIM_W-1:0])),
                                   pick_current(int'(lim[LIM_W-1:0])));
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("dq_current_reference_limiter_test: PASS");
        else
            $display("dq_current_reference_limiter_test: FAIL");
        $finish;
    end

endmodule
